### src/cslu_pkg.sv
package cslu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OPEN        = 2'd0,
    ERR_EARLY_QUOTE = 2'd1,
    ERR_UNTERM      = 2'd2,
    ERR_ESCAPE      = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    err_t        code;
  } result_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  val;
  } esc_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  function automatic esc_t simple_escape(input logic [7:0] b);
    esc_t e;
    e.hit = 1'b1;
    case (b)
      8'h61:     e.val = 8'd7;   // a
      8'h62:     e.val = 8'd8;   // b
      8'h66:     e.val = 8'd12;  // f
      8'h6E:     e.val = 8'd10;  // n
      8'h72:     e.val = 8'd13;  // r
      8'h74:     e.val = 8'd9;   // t
      8'h76:     e.val = 8'd11;  // v
      CH_BSLASH: e.val = CH_BSLASH;
      CH_APOS:   e.val = CH_APOS;
      CH_QUOTE:  e.val = CH_QUOTE;
      CH_QMARK:  e.val = CH_QMARK;
      default: begin
        e.hit = 1'b0;
        e.val = 8'h00;
      end
    endcase
    return e;
  endfunction

endpackage

### src/c_string_literal_unescaper_unit.sv
// An accepted input item waits in the input register until the output queue has room,
//   then is decoded and its results are written into the output queue.
// Throughput: one input item per cycle while each item causes at most one result and
//   out_stall is low; a non-digit, non-backslash item that ends an octal escape causes
//   two results, which leave the output queue at one per cycle while out_stall is low.
// Reset: synchronous, active-low rst_n empties the input stage and the output
//   queue and returns the decoder to expecting an opening quote.
module c_string_literal_unescaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_error_code
);
  import cslu_pkg::*;

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       room;
  logic       dec_en;
  logic       push0, push1;
  result_t    res0, res1, head;

  assign in_stall = in_v_r && !room;
  assign dec_en   = in_v_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
      last_r <= in_is_last;
    end
  end

  cslu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (dec_en),
    .byte_in (byte_r),
    .last_in (last_r),
    .push0   (push0),
    .push1   (push1),
    .res0    (res0),
    .res1    (res1)
  );

  cslu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (dec_en && push0),
    .push1     (dec_en && push1),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (head)
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.data;
  assign out_error_code = head.code;

endmodule

### src/cslu_decode.sv
module cslu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output logic              push0,
  output logic              push1,
  output cslu_pkg::result_t res0,
  output cslu_pkg::result_t res1
);
  import cslu_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_OCT  = 3'd3,
    PH_DROP = 3'd4
  } phase_t;

  typedef struct packed {
    logic    v;
    result_t r;
    phase_t  ph;
  } body_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] oct_val_r, oct_val_nxt;
  logic [1:0] oct_dig_r, oct_dig_nxt;

  logic       is_oct;
  logic [7:0] oct_shift;
  esc_t       esc;
  body_t      bs;

  function automatic body_t body_step(input logic [7:0] b, input logic last);
    body_t s;
    s.v  = 1'b1;
    s.r  = '0;
    s.ph = PH_BODY;
    if (b == CH_QUOTE) begin
      if (last) begin
        s.r.kind = KIND_END;
        s.ph     = PH_OPEN;
      end else begin
        s.r.kind = KIND_ERROR;
        s.r.code = ERR_EARLY_QUOTE;
        s.ph     = PH_DROP;
      end
    end else if (last) begin
      s.r.kind = KIND_ERROR;
      s.r.code = ERR_UNTERM;
      s.ph     = PH_OPEN;
    end else if (b == CH_BSLASH) begin
      s.v  = 1'b0;
      s.ph = PH_ESC;
    end else begin
      s.r.kind = KIND_BYTE;
      s.r.data = b;
    end
    return s;
  endfunction

  assign is_oct    = (byte_in >= CH_ZERO) && (byte_in <= CH_SEVEN);
  assign oct_shift = {oct_val_r[4:0], byte_in[2:0]};
  assign esc       = simple_escape(byte_in);
  assign bs        = body_step(byte_in, last_in);

  always_comb begin
    phase_nxt   = phase_r;
    oct_val_nxt = oct_val_r;
    oct_dig_nxt = oct_dig_r;
    push0       = 1'b0;
    push1       = 1'b0;
    res0        = '0;
    res1        = '0;
    case (phase_r)
      PH_OPEN: begin
        if (byte_in == CH_QUOTE && !last_in) begin
          phase_nxt = PH_BODY;
        end else begin
          push0     = 1'b1;
          res0.kind = KIND_ERROR;
          res0.code = ERR_OPEN;
          if (last_in) begin
            phase_nxt = PH_OPEN;
          end else begin
            phase_nxt = PH_DROP;
          end
        end
      end
      PH_BODY: begin
        push0     = bs.v;
        res0      = bs.r;
        phase_nxt = bs.ph;
      end
      PH_ESC: begin
        if (last_in) begin
          push0     = 1'b1;
          res0.kind = KIND_ERROR;
          res0.code = ERR_UNTERM;
          phase_nxt = PH_OPEN;
        end else if (is_oct) begin
          oct_val_nxt = {5'b0, byte_in[2:0]};
          oct_dig_nxt = 2'd1;
          phase_nxt   = PH_OCT;
        end else if (esc.hit) begin
          push0     = 1'b1;
          res0.kind = KIND_BYTE;
          res0.data = esc.val;
          phase_nxt = PH_BODY;
        end else begin
          push0     = 1'b1;
          res0.kind = KIND_ERROR;
          res0.code = ERR_ESCAPE;
          phase_nxt = PH_DROP;
        end
      end
      PH_OCT: begin
        if (is_oct) begin
          if (last_in) begin
            push0     = 1'b1;
            res0.kind = KIND_ERROR;
            res0.code = ERR_UNTERM;
            phase_nxt = PH_OPEN;
          end else if (oct_dig_r == OCT_MAX_DIGITS - 2'd1) begin
            // third digit closes the escape
            push0     = 1'b1;
            res0.kind = KIND_BYTE;
            res0.data = oct_shift;
            phase_nxt = PH_BODY;
          end else begin
            oct_val_nxt = oct_shift;
            oct_dig_nxt = oct_dig_r + 2'd1;
          end
        end else begin
          // emit the value, then treat this byte as a body byte
          push0     = 1'b1;
          res0.kind = KIND_BYTE;
          res0.data = oct_val_r;
          push1     = bs.v;
          res1      = bs.r;
          phase_nxt = bs.ph;
        end
      end
      default: begin
        if (last_in) begin
          phase_nxt = PH_OPEN;
        end else begin
          phase_nxt = PH_DROP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
    end else if (en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct_val_r <= oct_val_nxt;
      oct_dig_r <= oct_dig_nxt;
    end
  end

endmodule

### src/cslu_fifo.sv
module cslu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic              push1,
  input  cslu_pkg::result_t d0,
  input  cslu_pkg::result_t d1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output cslu_pkg::result_t q
);
  import cslu_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;
  logic [FIFO_PTR_W-1:0]   wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign q         = mem_r[rd_ptr_r];
  // keep space for the two items one input can cause
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= d0;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= d1;
    end
  end

endmodule

### src/cslu_checker.sv
module cslu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [1:0] out_error_code
);
  import cslu_pkg::*;

  // no result appears the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a result on an empty output comes from an item accepted into the input register and then decoded into the queue
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("latency violated");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_END || out_kind == KIND_ERROR)
      && (out_kind == KIND_BYTE || out_byte == 8'h00)
      && (out_kind == KIND_ERROR || out_error_code == 2'd0))
    else $error("result fields inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_error_code))
    else $error("stalled result changed");

endmodule

bind c_string_literal_unescaper_unit cslu_checker u_cslu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_error_code (out_error_code)
);

### test/c_string_literal_unescaper_unit_test.sv
`timescale 1ns / 100ps

import cslu_pkg::*;

typedef enum logic [2:0] {
  ST_QUOTE,
  ST_BODY,
  ST_ESCAPE,
  ST_OCTAL,
  ST_SKIP
} scan_state_t;

typedef struct packed {
  logic [7:0] b;
  logic       last;
} raw_item_t;

class literal_scoreboard;
  result_t      expected_q[$];
  scan_state_t  st = ST_QUOTE;
  logic [7:0]   oct_val = 8'd0;
  logic [1:0]   oct_cnt = 2'd0;
  int unsigned  mismatches = 0;

  function void add(kind_t k, logic [7:0] d, err_t c);
    result_t r;
    r.kind = k;
    r.data = d;
    r.code = c;
    expected_q.push_back(r);
  endfunction

  function void restart();
    st = ST_QUOTE;
    oct_val = 8'd0;
    oct_cnt = 2'd0;
  endfunction

  function void body_char(logic [7:0] b, logic last);
    if (b == CH_QUOTE) begin
      if (last) begin
        add(KIND_END, 8'd0, ERR_OPEN);
        restart();
      end else begin
        add(KIND_ERROR, 8'd0, ERR_EARLY_QUOTE);
        st = ST_SKIP;
      end
    end else if (last) begin
      add(KIND_ERROR, 8'd0, ERR_UNTERM);
      restart();
    end else if (b == CH_BSLASH) begin
      st = ST_ESCAPE;
    end else begin
      add(KIND_BYTE, b, ERR_OPEN);
    end
  endfunction

  function void note_item(logic [7:0] b, logic last);
    logic [7:0] esc;
    logic       hit;
    logic       is_oct;
    is_oct = (b >= CH_ZERO) && (b <= CH_SEVEN);
    case (st)
      ST_QUOTE: begin
        if (b == CH_QUOTE && !last) begin
          st = ST_BODY;
        end else begin
          add(KIND_ERROR, 8'd0, ERR_OPEN);
          if (last) restart();
          else st = ST_SKIP;
        end
      end
      ST_BODY: body_char(b, last);
      ST_ESCAPE: begin
        hit = 1'b1;
        case (b)
          "a":       esc = 8'd7;
          "b":       esc = 8'd8;
          "f":       esc = 8'd12;
          "n":       esc = 8'd10;
          "r":       esc = 8'd13;
          "t":       esc = 8'd9;
          "v":       esc = 8'd11;
          CH_BSLASH, CH_APOS, CH_QUOTE, CH_QMARK: esc = b;
          default: begin
            hit = 1'b0;
            esc = 8'd0;
          end
        endcase
        if (last) begin
          add(KIND_ERROR, 8'd0, ERR_UNTERM);
          restart();
        end else if (is_oct) begin
          oct_val = {5'd0, b[2:0]};
          oct_cnt = 2'd1;
          st = ST_OCTAL;
        end else if (hit) begin
          add(KIND_BYTE, esc, ERR_OPEN);
          st = ST_BODY;
        end else begin
          add(KIND_ERROR, 8'd0, ERR_ESCAPE);
          st = ST_SKIP;
        end
      end
      ST_OCTAL: begin
        if (is_oct) begin
          if (last) begin
            add(KIND_ERROR, 8'd0, ERR_UNTERM);
            restart();
          end else begin
            // shift in the digit, keep the low 8 bits
            oct_val = {oct_val[4:0], b[2:0]};
            oct_cnt = oct_cnt + 2'd1;
            if (oct_cnt == OCT_MAX_DIGITS) begin
              add(KIND_BYTE, oct_val, ERR_OPEN);
              oct_val = 8'd0;
              oct_cnt = 2'd0;
              st = ST_BODY;
            end
          end
        end else begin
          // flush the value, then treat the byte as body text
          add(KIND_BYTE, oct_val, ERR_OPEN);
          oct_val = 8'd0;
          oct_cnt = 2'd0;
          st = ST_BODY;
          body_char(b, last);
        end
      end
      default: begin
        if (last) restart();
        else st = ST_SKIP;
      end
    endcase
  endfunction

  function void check_result(logic [1:0] k, logic [7:0] d, logic [1:0] c);
    result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result kind=%0d byte=0x%02h code=%0d", k, d, c);
    end else begin
      want = expected_q.pop_front();
      if (want.kind !== k || want.data !== d || want.code !== c) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected kind=%0d byte=0x%02h code=%0d, got kind=%0d byte=0x%02h code=%0d",
                   want.kind, want.data, want.code, k, d, c);
      end
    end
  endfunction
endclass

module c_string_literal_unescaper_unit_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_is_last;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_error_code;

  literal_scoreboard sb;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  bit          hold_req;
  raw_item_t   raw_q[$];

  logic [7:0] escape_chars [11] = '{"a", "b", "f", "n", "r", "t", "v",
                                    CH_BSLASH, CH_APOS, CH_QUOTE, CH_QMARK};

  c_string_literal_unescaper_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_error_code (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], i == s.len() - 1);
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_byte, in_is_last);
      if (out_valid && !out_stall) sb.check_result(out_kind, out_byte, out_error_code);
    end
  end

  initial begin
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("c_string_literal_unescaper_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned n;
    int unsigned r;
    bit          hold_issued;
    raw_item_t   it;

    sb = new;
    idle_pct    = 0;
    stall_pct   = 0;
    items_sent  = 0;
    hold_req    = 1'b0;
    hold_issued = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= 8'd0;
    in_is_last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no opening quote, lone quote, early close, three-digit octal of the top value,
    // octal flushed by text and by the closing quote, unknown escape, unterminated
    send_text("x");
    send_text("\"");
    send_text("\"\"x");
    send_text("\"\\3771\\0\"");
    send_text("\"\\12x\\qy");
    send_text("\"ab");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      target = items_sent + 500;
      while (items_sent < target) begin
        if (p == 0 && !hold_issued && items_sent > 150) begin
          hold_req = 1'b1;
          hold_issued = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          // noise: random bytes with scattered last flags
          repeat ($urandom_range(1, 6)) begin
            it.b = 8'($urandom_range(255));
            it.last = ($urandom_range(3) == 0);
            raw_q.push_back(it);
          end
        end else begin
          it.last = 1'b0;
          it.b = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_QUOTE;
          raw_q.push_back(it);
          n = $urandom_range(0, 8);
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
              do it.b = 8'($urandom_range(255));
              while (it.b == CH_QUOTE || it.b == CH_BSLASH);
              raw_q.push_back(it);
            end else if (r < 93) begin
              it.b = CH_BSLASH;
              raw_q.push_back(it);
              if (r < 65) begin
                it.b = escape_chars[$urandom_range(10)];
                raw_q.push_back(it);
              end else if (r < 88) begin
                repeat ($urandom_range(1, 3)) begin
                  it.b = CH_ZERO + 8'($urandom_range(7));
                  raw_q.push_back(it);
                end
              end else begin
                it.b = 8'($urandom_range(255));
                raw_q.push_back(it);
              end
            end else if (r < 96) begin
              it.b = CH_QUOTE;
              raw_q.push_back(it);
            end else begin
              it.b = 8'($urandom_range(255));
              raw_q.push_back(it);
            end
          end
          r = $urandom_range(99);
          it.last = 1'b1;
          if (r < 82) it.b = CH_QUOTE;
          else if (r < 90) it.b = 8'($urandom_range(255));
          else if (r < 95) it.b = CH_BSLASH;
          else it.b = CH_ZERO + 8'($urandom_range(7));
          raw_q.push_back(it);
        end
        while (raw_q.size() != 0) begin
          it = raw_q.pop_front();
          send_item(it.b, it.last);
        end
      end
      if (p == 1) begin
        // pause the sender until every result is out
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("c_string_literal_unescaper_unit: match");
    end else begin
      $display("c_string_literal_unescaper_unit: mismatch");
    end
    $finish;
  end

endmodule
